// ----- rtl/core/assert_macros.svh -----
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the frame buffer scroll engine modules.
// Each macro expects signals named clock and reset in the module that uses it.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define FBS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fbs assertion failed");

// Next-cycle implication, muted while reset is high.
`define FBS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fbs assertion failed");

`endif

// ----- rtl/core/fbs_pkg.sv -----
// -----------------------------------------------------------------------------
// fbs_pkg
// Types, codes and default sizes shared by the frame buffer scroll engine.
// -----------------------------------------------------------------------------
package fbs_pkg;

   localparam int DEF_FRAME_HEIGHT = 8;
   localparam int DEF_FRAME_WIDTH  = 32;
   localparam int DEF_COLOUR_BITS  = 24;

   typedef enum logic [2:0] {
      OP_WRITE = 3'd0,
      OP_UP    = 3'd1,
      OP_DOWN  = 3'd2,
      OP_LEFT  = 3'd3,
      OP_RIGHT = 3'd4,
      OP_READ  = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCROLL,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [2:0]  row_index;
      logic [4:0]  column_index;
      logic [23:0] pixel_colour;
      logic [5:0]  scroll_amount;
   } req_beat_type;

   typedef struct packed {
      logic [23:0] read_colour;
      logic        read_valid;
   } rsp_beat_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic mem_write;
      logic mem_read;
      logic scroll_step;
      logic clear_step;
      logic load_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      opcode_type op;
      logic       last_up;
      logic       last_down;
      logic       rsp_free;
   } sts_type;

endpackage

// ----- rtl/core/fbs_ctrl.sv -----
// -----------------------------------------------------------------------------
// fbs_ctrl
// Sequencer: clears the store after reset, then runs one item at a time.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fbs_pkg::sts_type sts,
   output fbs_pkg::cmd_type cmd
);
   import fbs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.last_up) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.op)
               OP_WRITE: begin
                  cmd.mem_write = 1'b1;
                  state_in      = ST_FINISH;
               end
               OP_READ: begin
                  cmd.mem_read = 1'b1;
                  state_in     = ST_FINISH;
               end
               OP_UP, OP_DOWN, OP_LEFT, OP_RIGHT: begin
                  state_in = ST_SCROLL;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if ((sts.op == OP_DOWN) || (sts.op == OP_RIGHT)) begin
               if (sts.last_down) begin
                  state_in = ST_DRAIN;
               end
            end else if (sts.last_up) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a completed scroll sweep always drains its last write before finishing
   `FBS_ASSERT_NXT(a_sweep_drains, (state_ff == ST_SCROLL) && (state_in != ST_SCROLL), state_ff == ST_DRAIN)

endmodule

// ----- rtl/core/fbs_datapath.sv -----
// -----------------------------------------------------------------------------
// fbs_datapath
// Pixel memory, sweep counters, scroll copy pipeline and result register.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbs_datapath #(
   parameter int FRAME_HEIGHT = fbs_pkg::DEF_FRAME_HEIGHT,
   parameter int FRAME_WIDTH  = fbs_pkg::DEF_FRAME_WIDTH,
   parameter int COLOUR_BITS  = fbs_pkg::DEF_COLOUR_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fbs_pkg::req_beat_type req_data,
   input  logic                  csr_write,
   input  logic [23:0]           csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fbs_pkg::rsp_beat_type rsp_data,
   input  fbs_pkg::cmd_type      cmd,
   output fbs_pkg::sts_type      sts
);
   import fbs_pkg::*;

   localparam int PIX_COUNT = FRAME_HEIGHT * FRAME_WIDTH;
   localparam int AW = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
   localparam int OW = $clog2(PIX_COUNT + 1);
   localparam int RW = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
   localparam int CW = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
   localparam int HB = $clog2(FRAME_HEIGHT + 1);
   localparam int WB = $clog2(FRAME_WIDTH + 1);

   logic [COLOUR_BITS-1:0] mem [PIX_COUNT];

   req_beat_type           item_ff;
   logic [AW-1:0]          pix_addr_ff;
   logic                   inside_ff;
   logic [HB-1:0]          kh_ff;
   logic [WB-1:0]          kw_ff;
   logic [OW-1:0]          offset_ff;
   logic [23:0]            fill_ff;
   logic [RW-1:0]          row_ff, row_in;
   logic [CW-1:0]          col_ff, col_in;
   logic [AW-1:0]          addr_ff, addr_in;
   logic                   wr_pend_ff;
   logic [AW-1:0]          wr_addr_ff;
   logic                   wr_fill_ff;
   logic [COLOUR_BITS-1:0] rd_data_ff;
   logic                   rsp_valid_ff;
   rsp_beat_type           rsp_ff;

   logic [HB-1:0]          kh_new;
   logic [WB-1:0]          kw_new;
   logic                   desc_new;
   opcode_type             op;
   logic                   desc;
   logic                   src_ok;
   logic [AW-1:0]          src_addr;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [COLOUR_BITS-1:0] mem_wdata;
   logic                   mem_re;
   logic [AW-1:0]          mem_raddr;
   logic                   is_read_hit;

   // saturate the amount at each frame dimension
   assign kh_new = (32'(req_data.scroll_amount) >= 32'(FRAME_HEIGHT)) ?
                   HB'(FRAME_HEIGHT) : HB'(req_data.scroll_amount);
   assign kw_new = (32'(req_data.scroll_amount) >= 32'(FRAME_WIDTH)) ?
                   WB'(FRAME_WIDTH) : WB'(req_data.scroll_amount);
   assign desc_new = (req_data.opcode == OP_DOWN) || (req_data.opcode == OP_RIGHT);

   assign op   = opcode_type'(item_ff.opcode);
   assign desc = (op == OP_DOWN) || (op == OP_RIGHT);

   // latch the item and set up the sweep
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff     <= req_data;
         pix_addr_ff <= AW'(32'(req_data.row_index) * 32'(FRAME_WIDTH)
                            + 32'(req_data.column_index));
         inside_ff   <= (32'(req_data.row_index) < 32'(FRAME_HEIGHT)) &&
                        (32'(req_data.column_index) < 32'(FRAME_WIDTH));
         kh_ff       <= kh_new;
         kw_ff       <= kw_new;
         if ((req_data.opcode == OP_UP) || (req_data.opcode == OP_DOWN)) begin
            offset_ff <= OW'(32'(kh_new) * 32'(FRAME_WIDTH));
         end else begin
            offset_ff <= OW'(kw_new);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (csr_write) begin
         fill_ff <= csr_data;
      end
   end

   // sweep counters: ascending for clear, up and left; descending for down, right
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      addr_in = addr_ff;
      if (cmd.accept) begin
         if (desc_new) begin
            row_in  = RW'(FRAME_HEIGHT - 1);
            col_in  = CW'(FRAME_WIDTH - 1);
            addr_in = AW'(PIX_COUNT - 1);
         end else begin
            row_in  = '0;
            col_in  = '0;
            addr_in = '0;
         end
      end else if (cmd.clear_step || (cmd.scroll_step && !desc)) begin
         addr_in = addr_ff + AW'(1);
         if (col_ff == CW'(FRAME_WIDTH - 1)) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end else if (cmd.scroll_step) begin
         addr_in = addr_ff - AW'(1);
         if (col_ff == '0) begin
            col_in = CW'(FRAME_WIDTH - 1);
            row_in = row_ff - RW'(1);
         end else begin
            col_in = col_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         addr_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         addr_ff <= addr_in;
      end
   end

   // source pixel of the current destination, or fill when vacated
   always_comb begin
      case (op)
         OP_UP: begin
            src_ok   = (32'(row_ff) + 32'(kh_ff)) < 32'(FRAME_HEIGHT);
            src_addr = addr_ff + AW'(offset_ff);
         end
         OP_DOWN: begin
            src_ok   = 32'(row_ff) >= 32'(kh_ff);
            src_addr = addr_ff - AW'(offset_ff);
         end
         OP_LEFT: begin
            src_ok   = (32'(col_ff) + 32'(kw_ff)) < 32'(FRAME_WIDTH);
            src_addr = addr_ff + AW'(offset_ff);
         end
         OP_RIGHT: begin
            src_ok   = 32'(col_ff) >= 32'(kw_ff);
            src_addr = addr_ff - AW'(offset_ff);
         end
         default: begin
            src_ok   = 1'b0;
            src_addr = addr_ff;
         end
      endcase
   end

   // copy pipeline: read this cycle, write in the next
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= cmd.scroll_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scroll_step) begin
         wr_addr_ff <= addr_ff;
         wr_fill_ff <= !src_ok;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (wr_pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = wr_addr_ff;
         mem_wdata = wr_fill_ff ? COLOUR_BITS'(fill_ff) : rd_data_ff;
      end else if (cmd.mem_write && inside_ff) begin
         mem_we    = 1'b1;
         mem_waddr = pix_addr_ff;
         mem_wdata = COLOUR_BITS'(item_ff.pixel_colour);
      end
   end

   assign mem_re    = cmd.mem_read || (cmd.scroll_step && src_ok);
   assign mem_raddr = cmd.mem_read ? pix_addr_ff : src_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // result register
   assign is_read_hit = (op == OP_READ) && inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.read_valid  <= is_read_hit;
         rsp_ff.read_colour <= is_read_hit ? 24'(rd_data_ff) : 24'd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign sts.op        = op;
   assign sts.last_up   = (addr_ff == AW'(PIX_COUNT - 1));
   assign sts.last_down = (addr_ff == '0);
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

   `FBS_ASSERT_IMP(a_one_writer, 1'b1, $onehot0({wr_pend_ff, cmd.mem_write, cmd.clear_step}))
   `FBS_ASSERT_IMP(a_one_reader, 1'b1, $onehot0({cmd.mem_read, cmd.scroll_step}))
   `FBS_ASSERT_IMP(a_load_free, cmd.load_rsp, !rsp_valid_ff || !rsp_stall)
   `FBS_ASSERT_NXT(a_rsp_follows, cmd.load_rsp, rsp_valid)

endmodule

// ----- rtl/core/frame_buffer_scroll_engine.sv -----
// -----------------------------------------------------------------------------
// frame_buffer_scroll_engine
// Pixel frame store with single-pixel write/read and whole-frame scrolling.
// -----------------------------------------------------------------------------
// The block holds a FRAME_HEIGHT x FRAME_WIDTH store of colours in one
// single-port-write, single-port-read memory and handles one request at a time.
// After reset it sweeps the memory to zero, one pixel per cycle, covering all
// FRAME_HEIGHT*FRAME_WIDTH pixels (256 at the default size). Requests are held
// off during that sweep, but fill colour writes are taken at any time. A pixel
// write, pixel read or unused opcode passes from decode to finish, where its
// response is loaded once the output register is free; the block then returns
// to idle for the next request. A scroll copies every pixel through the
// memory's one read and one write port, which sets its pace, then drains the
// last copy before its response is loaded. Every request returns exactly one
// response beat, held in an output register. A stalled response therefore does
// not block acceptance of the next request; only that request's own response
// waits for the register to free up. csr_ready is always high.
// -----------------------------------------------------------------------------
module frame_buffer_scroll_engine #(
   parameter int FRAME_HEIGHT = fbs_pkg::DEF_FRAME_HEIGHT,
   parameter int FRAME_WIDTH  = fbs_pkg::DEF_FRAME_WIDTH,
   parameter int COLOUR_BITS  = fbs_pkg::DEF_COLOUR_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fbs_pkg::req_beat_type req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fbs_pkg::rsp_beat_type rsp_data,
   // fill colour register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [23:0]           csr_data
);
   import fbs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // the fill register accepts a write in any cycle
   assign csr_ready = 1'b1;

   // sequencer: clear sweep, decode, scroll sweep, drain, finish
   fbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // memory, sweep counters, copy pipeline and response register
   fbs_datapath #(
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .FRAME_WIDTH  (FRAME_WIDTH),
      .COLOUR_BITS  (COLOUR_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
